/* src/q_learning_table_engine_macros.svh */
// Assertion macros shared by the Q-learning table engine RTL.
// Each macro expects clk and arst_n in scope at the point of use.
`ifndef Q_LEARNING_TABLE_ENGINE_MACROS_SVH
`define Q_LEARNING_TABLE_ENGINE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define QLTE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define QLTE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/qlte_pkg.sv */
// Shared types and constants of the Q-learning table engine.
// No dependencies; imported by the divider and the top level.
`default_nettype none

package qlte_pkg;

	localparam int IDX_W      = 4;   // state / move field width
	localparam int Q_W        = 32;  // Q16.16 value width
	localparam int FRAC_W     = 16;  // 0.16 fraction width
	localparam int RATE_W     = 17;  // rate width, 65536 = one
	localparam int CNT_W      = 5;   // move count width
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;
	localparam int NUM_W      = FRAC_W + CNT_W;  // choose dividend
	localparam int DEN_W      = FRAC_W + 1;      // choose divisor
	localparam int QUOT_W     = CNT_W;           // quotient stays below move count

	localparam logic [RATE_W-1:0] ONE_Q16 = 17'h10000;
	localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

	localparam logic ACT_CHOOSE = 1'b0;
	localparam logic ACT_UPDATE = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MOVE_COUNT = 2'd0,
		REG_GREEDY     = 2'd1,
		REG_LEARN_RATE = 2'd2,
		REG_DISCOUNT   = 2'd3
	} reg_idx_t;

	localparam logic [CNT_W-1:0]  RST_MOVE_COUNT = 5'd16;
	localparam logic [FRAC_W-1:0] RST_GREEDY     = 16'd6554;
	localparam logic [RATE_W-1:0] RST_LEARN_RATE = 17'd6554;
	localparam logic [RATE_W-1:0] RST_DISCOUNT   = 17'd58982;

endpackage

`default_nettype wire

/* src/q_learning_table_engine.sv */
// Q-learning table engine: epsilon-greedy move choice and Q16.16 value update.
// Accept to result register: greedy choose reads then finishes, exploratory choose adds the
// divider, update reads twice, multiplies, finishes. One word in flight: a new word is
// taken once its result is loaded; an update is paced by the read-read-multiply-multiply
// chain on the value RAM. Reset: registers take their defaults, then a clear sweep writes
// zero to every value entry and to the best-move table; in_stall stays high meanwhile.
`default_nettype none

module q_learning_table_engine #(
	parameter int STATE_COUNT = 16,
	parameter int MOVE_LIMIT  = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_write,
	input  logic [qlte_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [qlte_pkg::CFG_DATA_W-1:0]    cfg_data,
	// input word
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               action,
	input  logic [qlte_pkg::IDX_W-1:0]         state_index,
	input  logic [qlte_pkg::IDX_W-1:0]         taken_move,
	input  logic [qlte_pkg::IDX_W-1:0]         reached_state,
	input  logic signed [qlte_pkg::Q_W-1:0]    reward,
	input  logic [qlte_pkg::FRAC_W-1:0]        random_fraction,
	// result word
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [qlte_pkg::IDX_W-1:0]         chosen_move,
	output logic signed [qlte_pkg::Q_W-1:0]    updated_value,
	output logic [qlte_pkg::IDX_W-1:0]         best_move,
	output logic                               saturated
);
	import qlte_pkg::*;

`include "q_learning_table_engine_macros.svh"

	localparam int DEPTH   = STATE_COUNT * MOVE_LIMIT;
	localparam int VAL_AW  = $clog2(DEPTH);
	localparam int BEST_AW = $clog2(STATE_COUNT);

	typedef enum logic [2:0] {
		ST_CLR,   // clear sweep after reset
		ST_IDLE,  // waiting for a word; RAM reads follow the input ports
		ST_RD1,   // best[n], best[s], Q[s][a] available
		ST_RD2,   // Q[n][best n], Q[s][best s] available
		ST_MUL,   // lr * (reward + gamma*Qn)
		ST_DIV,   // exploratory pick in the divider
		ST_FIN    // load result register and write back
	} state_t;

	// fold a 4-bit index into 0..lim-1 by repeated subtraction (at most 8 steps)
	function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W-1:0] v,
		input int unsigned lim);
		logic [IDX_W-1:0] w;
		w = v;
		for (int i = 0; i < 8; i++) begin
			if (32'(w) >= lim) begin
				w = w - IDX_W'(lim);
			end
		end
		return w;
	endfunction

	function automatic logic [VAL_AW-1:0] val_addr(input logic [BEST_AW-1:0] st,
		input logic [IDX_W-1:0] mv);
		return VAL_AW'(st) * VAL_AW'(MOVE_LIMIT) + VAL_AW'(mv);
	endfunction

	// ---------------- configuration registers ----------------
	logic [CNT_W-1:0]  move_count_q;
	logic [FRAC_W-1:0] eps_q;
	logic [RATE_W-1:0] lr_q;
	logic [RATE_W-1:0] gm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_count_q <= RST_MOVE_COUNT;
			eps_q        <= RST_GREEDY;
			lr_q         <= RST_LEARN_RATE;
			gm_q         <= RST_DISCOUNT;
		end else if (cfg_write) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MOVE_COUNT: move_count_q <= cfg_data[CNT_W-1:0];
				REG_GREEDY:     eps_q        <= cfg_data[FRAC_W-1:0];
				REG_LEARN_RATE: lr_q         <= cfg_data[RATE_W-1:0];
				REG_DISCOUNT:   gm_q         <= cfg_data[RATE_W-1:0];
			endcase
		end
	end

	// rates above one act as one; move count clamped to 1..MOVE_LIMIT
	logic [RATE_W-1:0] lr_c, gm_c, keep_c;
	logic [CNT_W-1:0]  cnt_c;

	assign lr_c   = (lr_q > ONE_Q16) ? ONE_Q16 : lr_q;
	assign gm_c   = (gm_q > ONE_Q16) ? ONE_Q16 : gm_q;
	assign keep_c = ONE_Q16 - lr_c;

	always_comb begin
		cnt_c = move_count_q;
		if (move_count_q == '0) begin
			cnt_c = CNT_W'(1);
		end else if (32'(move_count_q) > MOVE_LIMIT) begin
			cnt_c = CNT_W'(MOVE_LIMIT);
		end
	end

	// ---------------- sequencer state ----------------
	state_t             state_q;
	logic [VAL_AW-1:0]  clr_addr_q;

	// held word
	logic               act_q;
	logic [BEST_AW-1:0] s_q;
	logic [BEST_AW-1:0] n_q;
	logic [IDX_W-1:0]   a_q;
	logic signed [Q_W-1:0] reward_q;
	logic [FRAC_W-1:0]  p_q;

	// datapath registers
	logic [IDX_W-1:0]      sb_q;      // best[s] at accept
	logic [IDX_W-1:0]      pick_q;    // chosen move of a choose
	logic signed [49:0]    keep_q;    // (1-lr) * Q[s][a]
	logic signed [33:0]    t_q;       // floor(gamma * Q[n][best n])
	logic signed [Q_W-1:0] qss_q;     // Q[s][best s]
	logic signed [52:0]    learn_q;   // lr * (reward + t)

	// result register
	logic                  out_valid_q;
	logic [IDX_W-1:0]      chosen_q;
	logic signed [Q_W-1:0] upd_q;
	logic [IDX_W-1:0]      best_q;
	logic                  sat_q;

	// ---------------- memories ----------------
	logic                  val_we;
	logic [VAL_AW-1:0]     val_wa, val_ra, val_rb;
	logic [Q_W-1:0]        val_wd;
	logic signed [Q_W-1:0] val_rd_a, val_rd_b;
	logic                  best_we;
	logic [BEST_AW-1:0]    best_wa, best_ra, best_rb;
	logic [IDX_W-1:0]      best_wd, best_rd_a, best_rd_b;

	// wrapped input indices
	logic [BEST_AW-1:0] s_in, n_in;
	logic [IDX_W-1:0]   a_in;

	assign s_in = BEST_AW'(wrap_idx(state_index, STATE_COUNT));
	assign n_in = BEST_AW'(wrap_idx(reached_state, STATE_COUNT));
	assign a_in = wrap_idx(taken_move, MOVE_LIMIT);

	// best table: port A next state, port B current state, both read at accept
	assign best_ra = n_in;
	assign best_rb = s_in;

	// value table: at accept read Q[s][a]; in RD1 read Q[n][best n] and Q[s][best s]
	assign val_ra = (state_q == ST_IDLE) ? val_addr(s_in, a_in) : val_addr(n_q, best_rd_a);
	assign val_rb = val_addr(s_q, best_rd_b);

	qlte_mem #(
		.WIDTH (Q_W),
		.DEPTH (DEPTH)
	) u_val_mem (
		.clk     (clk),
		.we      (val_we),
		.waddr   (val_wa),
		.wdata   (val_wd),
		.raddr_a (val_ra),
		.raddr_b (val_rb),
		.rdata_a (val_rd_a),
		.rdata_b (val_rd_b)
	);

	qlte_mem #(
		.WIDTH (IDX_W),
		.DEPTH (STATE_COUNT)
	) u_best_mem (
		.clk     (clk),
		.we      (best_we),
		.waddr   (best_wa),
		.wdata   (best_wd),
		.raddr_a (best_ra),
		.raddr_b (best_rb),
		.rdata_a (best_rd_a),
		.rdata_b (best_rd_b)
	);

	// ---------------- choose: exploratory pick ----------------
	logic               greedy;
	logic               div_start;
	logic               div_done;
	logic [QUOT_W-1:0]  div_quot;

	assign greedy    = (p_q <= eps_q);
	assign div_start = (state_q == ST_RD1) && (act_q == ACT_CHOOSE) && !greedy;

	qlte_pick_div u_pick_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (NUM_W'(p_q - eps_q) * NUM_W'(cnt_c)),
		.den    (DEN_W'(ONE_Q16) - DEN_W'(eps_q)),
		.done   (div_done),
		.quot   (div_quot)
	);

	// ---------------- update arithmetic ----------------
	logic signed [49:0] disc_prod;
	logic signed [34:0] target;
	logic signed [33:0] keep_fl;
	logic signed [36:0] learn_fl;
	logic signed [37:0] r_full;
	logic               sat_hi, sat_lo;
	logic signed [Q_W-1:0] r_sat;
	logic               better;
	logic               fin_go;

	// the value RAM output feeds the multipliers directly; products are registered
	assign disc_prod = $signed({1'b0, gm_c}) * val_rd_a;
	assign target    = 35'(reward_q) + 35'(t_q);

	// arithmetic shifts by 16 give the floor of each product
	assign keep_fl  = $signed(keep_q[49:16]);
	assign learn_fl = $signed(learn_q[52:16]);
	assign r_full   = 38'(keep_fl) + 38'(learn_fl);

	assign sat_hi = !r_full[37] && (r_full[37:31] != '0);
	assign sat_lo = r_full[37] && (r_full[37:31] != '1);
	assign r_sat  = sat_hi ? Q_MAX : (sat_lo ? Q_MIN : $signed(r_full[Q_W-1:0]));

	// the new value is compared with Q[s][best s] as read before the write: equal move means no change
	assign better = (a_q != sb_q) && (r_sat > qss_q);

	// result register free or draining this cycle
	assign fin_go = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	// ---------------- write back and clear sweep ----------------
	// reads of the next word start only after this write has landed, so no forwarding
	always_comb begin
		if (state_q == ST_CLR) begin
			val_we  = 1'b1;
			val_wa  = clr_addr_q;
			val_wd  = '0;
			best_we = clr_addr_q < VAL_AW'(STATE_COUNT);
			best_wa = BEST_AW'(clr_addr_q);
			best_wd = '0;
		end else begin
			val_we  = fin_go && (act_q == ACT_UPDATE);
			val_wa  = val_addr(s_q, a_q);
			val_wd  = r_sat;
			best_we = fin_go && (act_q == ACT_UPDATE) && better;
			best_wa = s_q;
			best_wd = a_q;
		end
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result may replace one that drains in the same cycle
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == VAL_AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_RD1;
					end
				end
				ST_RD1: begin
					if (act_q == ACT_UPDATE) begin
						state_q <= ST_RD2;
					end else if (greedy) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_RD2: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_FIN;
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			act_q    <= action;
			s_q      <= s_in;
			n_q      <= n_in;
			a_q      <= a_in;
			reward_q <= reward;
			p_q      <= random_fraction;
		end
		if (state_q == ST_RD1) begin
			sb_q   <= best_rd_b;
			pick_q <= best_rd_b;
			keep_q <= $signed({1'b0, keep_c}) * val_rd_a;
		end
		if (state_q == ST_RD2) begin
			t_q   <= $signed(disc_prod[49:16]);
			qss_q <= val_rd_b;
		end
		if (state_q == ST_MUL) begin
			learn_q <= $signed({1'b0, lr_c}) * target;
		end
		if (state_q == ST_DIV && div_done) begin
			pick_q <= div_quot[IDX_W-1:0];
		end
		if (fin_go) begin
			if (act_q == ACT_UPDATE) begin
				chosen_q <= '0;
				upd_q    <= r_sat;
				best_q   <= better ? a_q : sb_q;
				sat_q    <= sat_hi || sat_lo;
			end else begin
				chosen_q <= pick_q;
				upd_q    <= '0;
				best_q   <= sb_q;
				sat_q    <= 1'b0;
			end
		end
	end

	assign in_stall      = (state_q != ST_IDLE);
	assign out_valid     = out_valid_q;
	assign chosen_move   = chosen_q;
	assign updated_value = upd_q;
	assign best_move     = best_q;
	assign saturated     = sat_q;

	// ---------------- checks ----------------
	`QLTE_ASSERT_NOW(a_sat_on_rail, out_valid && saturated,
		updated_value == Q_MAX || updated_value == Q_MIN, "saturated flag off the rails")
	`QLTE_ASSERT_NOW(a_choose_clean, out_valid && (chosen_move != '0),
		updated_value == '0 && !saturated, "choose word carries update fields")
	`QLTE_ASSERT_NEXT(a_accept_reads, in_valid && !in_stall,
		state_q == ST_RD1, "accepted word did not start the read step")
	`QLTE_ASSERT_NOW(a_div_owned, div_done,
		state_q == ST_DIV, "divider finished outside the pick step")

endmodule

`default_nettype wire

/* src/qlte_mem.sv */
// Synchronous RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none

module qlte_mem #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [$clog2(DEPTH)-1:0]  waddr,
	input  logic [WIDTH-1:0]          wdata,
	input  logic [$clog2(DEPTH)-1:0]  raddr_a,
	input  logic [$clog2(DEPTH)-1:0]  raddr_b,
	output logic [WIDTH-1:0]          rdata_a,
	output logic [WIDTH-1:0]          rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

`default_nettype wire

/* src/qlte_pick_div.sv */
// Restoring divider for the exploratory pick, one quotient bit per cycle.
// Depends on qlte_pkg.
`default_nettype none

module qlte_pick_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [qlte_pkg::NUM_W-1:0]    num,
	input  logic [qlte_pkg::DEN_W-1:0]    den,
	output logic                          done,
	output logic [qlte_pkg::QUOT_W-1:0]   quot
);
	import qlte_pkg::*;

	localparam int SH_W   = DEN_W + QUOT_W - 1;  // divisor aligned to the top quotient bit
	localparam int STEP_W = $clog2(QUOT_W);

	logic [NUM_W-1:0]  rem_q;
	logic [SH_W-1:0]   dsh_q;
	logic [QUOT_W-1:0] quot_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic              fits;

	// dividend and shifted divisor both fit in SH_W bits
	assign fits = SH_W'(rem_q) >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(QUOT_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			dsh_q  <= SH_W'(den) << (QUOT_W - 1);
			quot_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= NUM_W'(SH_W'(rem_q) - dsh_q);
			end
			quot_q <= {quot_q[QUOT_W-2:0], fits};
			dsh_q  <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

`default_nettype wire
